/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, masked while reset is asserted (active low)
`define GDE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion lbl failed");

// Checked property, active during reset too
`define GDE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion lbl failed");

`endif

/* rtl/gde_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gde_pkg;

    // Control that travels beside the payload through every stage
    typedef struct packed {
        logic valid;
        logic zero;   // some scale was zero
        logic kill;   // result forced to zero
    } gde_ctrl_t;

    localparam int AlphaW    = 17;
    localparam int SigmaW    = 31;
    localparam int CoordW    = 32;
    localparam logic [AlphaW-1:0] ALPHA_ONE = 17'd65536;

    // Q.30 helpers
    localparam int Q30W = 31;
    localparam logic [63:0] Q30_HALF = 64'd1 << 29;
    localparam logic [Q30W-1:0] Q30_ONE = 31'd1 << 30;

    // Reciprocal of three, exact for 32-bit dividends with a shift of 33
    localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;

    // Depth of the merging pipeline
    localparam int MERGE_STAGES = 16;

endpackage

`default_nettype wire

/* rtl/gde_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

// One axis: offset, magnitude, overflow check, bit-per-stage divider, square
module gde_lane #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic signed [gde_pkg::CoordW-1:0] point,
    input  wire logic signed [gde_pkg::CoordW-1:0] center,
    input  wire logic        [gde_pkg::SigmaW-1:0] sigma,
    output logic             [2*(FRAC_BITS+4)-1:0] sq_o,
    output logic                                   ovf_o
);

    localparam int QB = FRAC_BITS + 4;    // quotient bits
    localparam int RW = FRAC_BITS + 35;   // remainder width
    localparam int MW = gde_pkg::CoordW + 1;

    logic [RW-1:0]             rem_reg [0:QB];
    logic [QB-1:0]             quo_reg [0:QB];
    logic [gde_pkg::SigmaW-1:0] sig_reg [0:QB];
    logic                      ovf_reg [0:QB];
    logic [2*QB-1:0]           sq_reg;
    logic                      ovf_out_reg;

    // Entry stage: offset and its magnitude
    logic signed [MW-1:0] diff;
    logic        [MW-1:0] mag;
    logic                 ovf_next;

    assign diff = {point[gde_pkg::CoordW-1], point} - {center[gde_pkg::CoordW-1], center};
    assign mag  = diff[MW-1] ? MW'(-diff) : MW'(diff);
    // ratio reaches 16 exactly when the offset reaches 16 scales
    assign ovf_next = {2'b00, mag} >= {sigma, 4'b0000};

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= RW'(mag) << FRAC_BITS;
            quo_reg[0] <= '0;
            sig_reg[0] <= sigma;
            ovf_reg[0] <= ovf_next;
        end
    end

    // Restoring division, one quotient bit per stage, top bit first
    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int B = QB - 1 - k;
        logic [RW-1:0] trial;
        logic          ge;
        logic [RW-1:0] rem_next;
        logic [QB-1:0] quo_next;

        assign trial    = RW'(sig_reg[k]) << B;
        assign ge       = rem_reg[k] >= trial;
        assign rem_next = ge ? rem_reg[k] - trial : rem_reg[k];
        assign quo_next = quo_reg[k] | (QB'(ge) << B);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= rem_next;
                quo_reg[k+1] <= quo_next;
                sig_reg[k+1] <= sig_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    // Square of the ratio
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg      <= (2*QB)'(quo_reg[QB]) * (2*QB)'(quo_reg[QB]);
            ovf_out_reg <= ovf_reg[QB];
        end
    end

    assign sq_o  = sq_reg;
    assign ovf_o = ovf_out_reg;

endmodule

`default_nettype wire

/* rtl/gde_merge.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sums the lane squares, evaluates exp(-E) and scales by the opacity
module gde_merge #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              en,
    input  wire logic        [2*(FRAC_BITS+4)-1:0] sq0,
    input  wire logic        [2*(FRAC_BITS+4)-1:0] sq1,
    input  wire logic        [2*(FRAC_BITS+4)-1:0] sq2,
    input  wire logic                              ovf,
    input  wire gde_pkg::gde_ctrl_t                ctl_i,
    input  wire logic        [gde_pkg::AlphaW-1:0] alpha_i,
    output logic             [gde_pkg::AlphaW-1:0] density_o,
    output gde_pkg::gde_ctrl_t                     ctl_o
);

    localparam int QB = FRAC_BITS + 4;
    localparam int SW = 2 * QB + 2;
    localparam int EW = FRAC_BITS + 4;
    localparam int UW = 27;
    localparam int MS = gde_pkg::MERGE_STAGES;
    localparam logic [EW:0] ELIM = (EW+1)'(16) << FRAC_BITS;

    gde_pkg::gde_ctrl_t          ctl_reg [0:MS-1];
    logic [gde_pkg::AlphaW-1:0]  alp_reg [0:MS-1];

    // Stage 1: exponent and range check
    logic [SW-1:0] sum;
    logic [SW-1:0] e_full;
    logic          big;
    logic [EW-1:0] e_reg;

    assign sum    = SW'(sq0) + SW'(sq1) + SW'(sq2);
    assign e_full = sum >> (FRAC_BITS + 1);
    assign big    = e_full >= SW'(ELIM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MS; i++) ctl_reg[i] <= '0;
        end else if (en) begin
            ctl_reg[0] <= '{valid: ctl_i.valid, zero: ctl_i.zero,
                            kill: ctl_i.zero | ovf | big};
            for (int i = 1; i < MS; i++) ctl_reg[i] <= ctl_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg      <= e_full[EW-1:0];
            alp_reg[0] <= alpha_i;
            for (int i = 1; i < MS; i++) alp_reg[i] <= alp_reg[i-1];
        end
    end

    // Stage 2: u = x / 256 with x in Q4.30
    logic [35:0]   x_wide;
    logic [UW-1:0] u_reg;
    assign x_wide = (36'(e_reg) << (30 - FRAC_BITS)) + 36'd128;

    // Stages 3..5: powers of u, rounded Q.30 products
    logic [63:0]   m_u2, m_u3, m_u4;
    logic [UW-1:0] u2_reg, u_d1_reg;
    logic [UW-1:0] u3_reg, u2_d1_reg, u_d2_reg;
    logic [UW-1:0] u4_reg, u3_d1_reg, u2_d2_reg, u_d3_reg;

    assign m_u2 = 64'(u_reg) * 64'(u_reg) + gde_pkg::Q30_HALF;
    assign m_u3 = 64'(u2_reg) * 64'(u_d1_reg) + gde_pkg::Q30_HALF;
    assign m_u4 = 64'(u3_reg) * 64'(u_d2_reg) + gde_pkg::Q30_HALF;

    // Stage 6: u4 / 24 and u3 / 6 by reciprocal of three
    logic [63:0]   r24, r6;
    logic [30:0]   d24_reg, d6_reg;
    logic [UW-1:0] u2_d3_reg, u_d4_reg;

    assign r24 = 64'(u4_reg >> 3) * 64'(gde_pkg::RECIP3);
    assign r6  = 64'(u3_d1_reg >> 1) * 64'(gde_pkg::RECIP3);

    // Stage 7: series value
    logic signed [33:0] p_sum;
    assign p_sum = 34'(gde_pkg::Q30_ONE) - 34'(u_d4_reg) + 34'(u2_d3_reg >> 1)
                 + 34'(d24_reg) - 34'(d6_reg);

    // Stages 8..15: eight squarings
    logic [gde_pkg::Q30W-1:0] pw_reg [0:8];

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg     <= x_wide[UW+7:8];
            u2_reg    <= UW'(m_u2 >> 30);
            u_d1_reg  <= u_reg;
            u3_reg    <= UW'(m_u3 >> 30);
            u2_d1_reg <= u2_reg;
            u_d2_reg  <= u_d1_reg;
            u4_reg    <= UW'(m_u4 >> 30);
            u3_d1_reg <= u3_reg;
            u2_d2_reg <= u2_d1_reg;
            u_d3_reg  <= u_d2_reg;
            d24_reg   <= 31'(r24 >> 33);
            d6_reg    <= 31'(r6 >> 33);
            u2_d3_reg <= u2_d2_reg;
            u_d4_reg  <= u_d3_reg;
            pw_reg[0] <= p_sum[gde_pkg::Q30W-1:0];
        end
    end

    for (genvar k = 0; k < 8; k++) begin : g_sq
        logic [63:0] prod;
        assign prod = 64'(pw_reg[k]) * 64'(pw_reg[k]) + gde_pkg::Q30_HALF;
        always_ff @(posedge aclk) begin
            if (en) pw_reg[k+1] <= gde_pkg::Q30W'(prod >> 30);
        end
    end

    // Stage 16: opacity scaling, saturation and forced zero
    logic [63:0]                dprod;
    logic [63:0]                dval;
    logic [gde_pkg::AlphaW-1:0] dens_next;
    logic [gde_pkg::AlphaW-1:0] dens_reg;

    assign dprod = 64'(alp_reg[MS-2]) * 64'(pw_reg[8]) + gde_pkg::Q30_HALF;
    assign dval  = dprod >> 30;

    always_comb begin
        if (ctl_reg[MS-2].kill) begin
            dens_next = '0;
        end else if (dval > 64'(gde_pkg::ALPHA_ONE)) begin
            dens_next = gde_pkg::ALPHA_ONE;
        end else begin
            dens_next = dval[gde_pkg::AlphaW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) dens_reg <= dens_next;
    end

    assign density_o = dens_reg;
    assign ctl_o     = ctl_reg[MS-1];

endmodule

`default_nettype wire

/* rtl/gaussian_density_eval.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Bits  Contents
// s_axis    in   304   point xyz, center xyz, sigma xyz, alpha
// m_axis    out  24+1  density in tdata, zero_scale in tuser
//
// One transaction per cycle sustained while m_axis is not stalled; the per-axis divider lanes
// feed the merge pipeline.
// The whole pipeline advances when the output register is empty or taken.
// aresetn clears the control bits only; no clearing pass.
// A stall at m_axis holds every stage and drops s_tready.
module gaussian_density_eval #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // point_x, point_y, point_z, center_x, center_y, center_z,
    // sigma_x, sigma_y, sigma_z, alpha, zero pad
    input  wire logic [303:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // density, zero pad
    output logic [23:0]       m_tdata,
    // zero_scale
    output logic [0:0]        m_tuser
);

    localparam int QB = FRAC_BITS + 4;
    localparam int LL = QB + 2;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Field unpacking
    logic signed [31:0] pt [0:2];
    logic signed [31:0] ct [0:2];
    logic        [30:0] sg [0:2];
    logic        [16:0] alpha_in;
    logic        [16:0] alpha_sat;
    logic               zero_any;

    assign pt[0] = s_tdata[31:0];
    assign pt[1] = s_tdata[63:32];
    assign pt[2] = s_tdata[95:64];
    assign ct[0] = s_tdata[127:96];
    assign ct[1] = s_tdata[159:128];
    assign ct[2] = s_tdata[191:160];
    assign sg[0] = s_tdata[222:192];
    assign sg[1] = s_tdata[253:223];
    assign sg[2] = s_tdata[284:254];
    assign alpha_in = s_tdata[301:285];

    assign zero_any  = (sg[0] == '0) || (sg[1] == '0) || (sg[2] == '0);
    assign alpha_sat = (alpha_in > gde_pkg::ALPHA_ONE) ? gde_pkg::ALPHA_ONE : alpha_in;

    // Lanes, one per axis
    logic [2*QB-1:0] sq [0:2];
    logic            ovf [0:2];

    for (genvar i = 0; i < 3; i++) begin : g_lane
        gde_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .aclk   (aclk),
            .en     (en),
            .point  (pt[i]),
            .center (ct[i]),
            .sigma  (sg[i]),
            .sq_o   (sq[i]),
            .ovf_o  (ovf[i])
        );
    end

    // Control and opacity ride alongside the lanes
    gde_pkg::gde_ctrl_t ctl_reg [0:LL-1];
    logic [16:0]        alp_reg [0:LL-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LL; i++) ctl_reg[i] <= '0;
        end else if (en) begin
            ctl_reg[0] <= '{valid: s_tvalid, zero: zero_any, kill: zero_any};
            for (int i = 1; i < LL; i++) ctl_reg[i] <= ctl_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            alp_reg[0] <= alpha_sat;
            for (int i = 1; i < LL; i++) alp_reg[i] <= alp_reg[i-1];
        end
    end

    // Merge stage
    logic [16:0]        density;
    gde_pkg::gde_ctrl_t ctl_out;

    gde_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .sq0       (sq[0]),
        .sq1       (sq[1]),
        .sq2       (sq[2]),
        .ovf       (ovf[0] | ovf[1] | ovf[2]),
        .ctl_i     (ctl_reg[LL-1]),
        .alpha_i   (alp_reg[LL-1]),
        .density_o (density),
        .ctl_o     (ctl_out)
    );

    assign m_tvalid = ctl_out.valid;
    assign m_tdata  = {7'b0, density};
    assign m_tuser  = ctl_out.zero;

endmodule

`default_nettype wire

/* rtl/gde_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Port-level checks on the density block
module gde_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // A stalled result stays offered
    `GDE_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)

    // A zero scale always comes with zero density
    `GDE_ASSERT(a_zero, aclk, aresetn, m_tvalid && m_tuser[0] |-> m_tdata == 24'd0)

    // Density never exceeds one
    `GDE_ASSERT(a_range, aclk, aresetn, m_tvalid |-> m_tdata <= 24'd65536)

    // Reset empties the pipeline
    `GDE_ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_tvalid)

endmodule

bind gaussian_density_eval gde_checker u_gde_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* tb/sv/tb_gaussian_density_eval.sv */
`timescale 1ns / 1ps

module tb_gaussian_density_eval;

    localparam int FRAC = 16;
    localparam logic [63:0] RATIO_MAX = 64'd16 << FRAC;
    localparam logic [63:0] EXP_MAX   = 64'd16 << FRAC;
    localparam int LATENCY = FRAC + 22;

    typedef struct packed {
        logic [16:0] alpha;
        logic [30:0] sigma_z;
        logic [30:0] sigma_y;
        logic [30:0] sigma_x;
        logic signed [31:0] center_z;
        logic signed [31:0] center_y;
        logic signed [31:0] center_x;
        logic signed [31:0] point_z;
        logic signed [31:0] point_y;
        logic signed [31:0] point_x;
    } splat_t;

    typedef struct packed {
        logic [16:0] density;
        logic        zero_scale;
    } density_t;

    // Q.30 product, rounded half up
    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    // exp(-e) in Q.30 via a quartic of e/256, squared eight times
    function automatic logic [63:0] falloff_q30(input logic [63:0] e);
        logic [63:0] u, u2, u3, u4, p;
        u  = ((e << (30 - FRAC)) + 64'd128) >> 8;
        u2 = mul_q30(u, u);
        u3 = mul_q30(u2, u);
        u4 = mul_q30(u3, u);
        p  = ((64'd1 << 30) - u) + u2 / 2 + u4 / 24 - u3 / 6;
        for (int k = 0; k < 8; k++) p = mul_q30(p, p);
        return p;
    endfunction

    function automatic density_t predict_density(input splat_t it);
        density_t r;
        logic signed [63:0] pt [3];
        logic signed [63:0] ct [3];
        logic [63:0] sg [3];
        logic signed [63:0] d;
        logic [63:0] a, q, sumsq, e, al, dn;
        pt[0] = it.point_x;  pt[1] = it.point_y;  pt[2] = it.point_z;
        ct[0] = it.center_x; ct[1] = it.center_y; ct[2] = it.center_z;
        sg[0] = it.sigma_x;  sg[1] = it.sigma_y;  sg[2] = it.sigma_z;
        r = '0;
        sumsq = 0;
        if (sg[0] == 0 || sg[1] == 0 || sg[2] == 0) begin
            r.zero_scale = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            d = pt[i] - ct[i];
            a = (d < 0) ? -d : d;
            q = (a << FRAC) / sg[i];
            if (q >= RATIO_MAX) return r;
            sumsq += q * q;
        end
        e = sumsq >> (FRAC + 1);
        if (e >= EXP_MAX) return r;
        al = (it.alpha > 17'd65536) ? 64'd65536 : 64'(it.alpha);
        dn = (al * falloff_q30(e) + (64'd1 << 29)) >> 30;
        if (dn > 64'd65536) dn = 64'd65536;
        r.density = dn[16:0];
        return r;
    endfunction

    class density_scoreboard;
        density_t pending[$];
        int errors;

        function void note_input(splat_t it);
            pending = {pending, predict_density(it)};
        endfunction

        function void check_result(density_t got);
            density_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.density !== want.density)
                $display("%0t: density expected %0d actual %0d", $time, want.density,
                         got.density);
            if (got.zero_scale !== want.zero_scale)
                $display("%0t: zero_scale expected %0b actual %0b", $time,
                         want.zero_scale, got.zero_scale);
            if (got !== want) errors++;
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_tvalid, s_tready, m_tvalid, m_tready;
    logic [303:0] s_tdata;
    logic [23:0] m_tdata;
    logic [0:0] m_tuser;
    bit idle_on;
    density_scoreboard sb;

    gaussian_density_eval #(.FRAC_BITS(FRAC)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("gaussian_density_eval: mismatch");
        $finish;
    end

    // Result side: random stall bursts while idle_on is set, checked at the rising edge
    initial begin
        m_tready = 0;
        @(negedge aclk);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
            end
            m_tready <= 1;
            @(negedge aclk);
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready)
            sb.check_result('{density: m_tdata[16:0], zero_scale: m_tuser[0]});

    task automatic send_splat(input splat_t it);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tdata  <= {2'd0, it};
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(it);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            2: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
            default: return $urandom_range(0, 32'h0004_0000);
        endcase
    endfunction

    function automatic logic [30:0] rand_sigma();
        case ($urandom_range(0, 9))
            0: return 31'd0;
            1: return 31'($urandom);
            2: return 31'h7FFF_FFFF;
            default: return 31'($urandom_range(32'h0000_4000, 32'h0004_0000));
        endcase
    endfunction

    // Mostly points near the center so the falloff is exercised
    function automatic splat_t rand_splat();
        splat_t it;
        it.center_x = rand_coord();
        it.center_y = rand_coord();
        it.center_z = rand_coord();
        it.sigma_x = rand_sigma();
        it.sigma_y = rand_sigma();
        it.sigma_z = rand_sigma();
        if ($urandom_range(0, 3) != 0) begin
            it.point_x = it.center_x + 32'($signed(18'($urandom)));
            it.point_y = it.center_y + 32'($signed(18'($urandom)));
            it.point_z = it.center_z + 32'($signed(18'($urandom)));
        end else begin
            it.point_x = rand_coord();
            it.point_y = rand_coord();
            it.point_z = rand_coord();
        end
        it.alpha = ($urandom_range(0, 7) == 0) ? 17'($urandom)
                                                : 17'($urandom_range(0, 65536));
        return it;
    endfunction

    initial begin
        splat_t it;
        int wait_cycles;
        sb = new();
        idle_on = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed: exact center, unit and minimal alpha
        it = '{default: '0};
        it.sigma_x = 31'h10000; it.sigma_y = 31'h10000; it.sigma_z = 31'h10000;
        it.alpha = 17'd65536;
        send_splat(it);
        it.alpha = 17'd0;
        send_splat(it);
        // alpha above one saturates
        it.alpha = 17'h1FFFF;
        send_splat(it);
        // one sigma offset on x and y, two sigma on z
        it.alpha = 17'd65536;
        it.point_x = 32'h10000; send_splat(it);
        it.point_y = -32'sh10000; send_splat(it);
        it.point_z = 32'h20000; send_splat(it);
        // exponent just under, at and past the limit (sqrt(32) ~ 5.657)
        it = '{default: '0};
        it.sigma_x = 31'h10000; it.sigma_y = 31'h10000; it.sigma_z = 31'h10000;
        it.alpha = 17'd65536;
        it.point_x = 32'h0005_A000; send_splat(it);
        it.point_x = 32'h0005_A828; send_splat(it);
        it.point_x = 32'h0005_B000; send_splat(it);
        // ratio overflow on a single axis
        it.point_x = 32'h0010_0000; send_splat(it);
        it.point_x = 32'h000F_FFFF; it.sigma_x = 31'h10000; send_splat(it);
        // zero scale on each axis
        it.point_x = 0;
        it.sigma_x = 0; send_splat(it);
        it.sigma_x = 31'h10000; it.sigma_y = 0; send_splat(it);
        it.sigma_y = 31'h10000; it.sigma_z = 0; send_splat(it);
        // extreme coordinates and scales
        it = '{default: '0};
        it.point_x = 32'h7FFF_FFFF; it.center_x = 32'h8000_0000;
        it.point_y = 32'h8000_0000; it.center_y = 32'h7FFF_FFFF;
        it.point_z = 32'hFFFF_FFFF; it.center_z = 32'h7FFF_FFFF;
        it.sigma_x = 31'h7FFF_FFFF; it.sigma_y = 31'h7FFF_FFFF; it.sigma_z = 31'h7FFF_FFFF;
        it.alpha = 17'd65536;
        send_splat(it);
        it.sigma_x = 31'd1; send_splat(it);
        it = '{default: '0};
        it.sigma_x = 31'd1; it.sigma_y = 31'd1; it.sigma_z = 31'd1;
        it.point_z = 32'd1; it.alpha = 17'd65535;
        send_splat(it);
        it.point_z = 0; send_splat(it);

        // Random part: idling bursts, then a clean stretch at the end
        idle_on = 1;
        for (int n = 0; n < 550; n++) begin
            if (n == 470) idle_on = 0;
            send_splat(rand_splat());
        end
        s_tvalid <= 0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 100000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0 && wait_cycles < 100000)
            $display("gaussian_density_eval: match");
        else
            $display("gaussian_density_eval: mismatch");
        $finish;
    end

endmodule
